// ----- rtl/mvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg
// shared widths, types and reset constants for the 4x4 matrix-vector block
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int MatrixDim = 4;
  localparam int NumRegs   = (MatrixDim * MatrixDim) / 2;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 64;
  localparam int CoefW     = 32;
  localparam int ProdW     = 2 * CoefW;
  localparam int PairW     = ProdW + 1;
  localparam int SumW      = ProdW + 2;
  localparam int FracBits  = 16;
  localparam int WordW     = MatrixDim * CoefW;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic        [CfgDataW-1:0] cfg_word_t;

  // load enables of the three lane pipeline stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_en_t;

  // identity matrix, two coefficients per register
  localparam cfg_word_t CfgReset [NumRegs] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

// ----- rtl/mvt_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_lane
// one matrix row: four products, two-level add tree, floor shift and clamp
// ----------------------------------------------------------------------------
module mvt_lane import mvt_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  coef_t     coef_i [MatrixDim],
  input  coef_t     vec_i  [MatrixDim],
  output coef_t     res_o,
  output logic      sat_o
);

  logic signed [ProdW-1:0] prod_q [MatrixDim];
  logic signed [PairW-1:0] pair_q [MatrixDim/2];
  logic signed [SumW-1:0]  sum_q;
  logic                    ovf;

  always_ff @(posedge clk_i) begin
    if (en_i.ld1) begin
      for (int c = 0; c < MatrixDim; c++) begin
        prod_q[c] <= coef_i[c] * vec_i[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld2) begin
      for (int k = 0; k < MatrixDim/2; k++) begin
        pair_q[k] <= PairW'(prod_q[2*k]) + PairW'(prod_q[2*k+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld3) begin
      sum_q <= SumW'(pair_q[0]) + SumW'(pair_q[1]);
    end
  end

  // floor shift keeps bits above the fraction; in range only when the top
  // bits all copy the result sign bit
  assign ovf = !((&sum_q[SumW-1:FracBits+CoefW-1]) || !(|sum_q[SumW-1:FracBits+CoefW-1]));

  always_comb begin
    if (!ovf) begin
      res_o = sum_q[FracBits+CoefW-1:FracBits];
    end else if (sum_q[SumW-1]) begin
      res_o = {1'b1, {(CoefW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(CoefW-1){1'b1}}};
    end
  end

  assign sat_o = ovf;

endmodule

// ----- rtl/mvt_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_merge
// gathers the four lane results and the clamp flags into the output register
// ----------------------------------------------------------------------------
module mvt_merge import mvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  coef_t            res_i [MatrixDim],
  input  logic [MatrixDim-1:0] sat_i,
  output logic             ready_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [WordW-1:0] m_axis_tdata,
  output logic             m_axis_tuser
);

  logic             valid_q, valid_d;
  logic [WordW-1:0] data_q;
  logic             sat_q;

  assign ready_o = !valid_q || m_axis_tready;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      for (int r = 0; r < MatrixDim; r++) begin
        data_q[r*CoefW +: CoefW] <= res_i[r];
      end
      sat_q <= |sat_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = sat_q;

endmodule

// ----- rtl/mat4_vector_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_vector_transform
// 4x4 matrix times 4-vector, signed Q16.16, saturating
// ----------------------------------------------------------------------------
// One vector word enters per clock and one result word leaves per clock while
// the output is not stalled; each word passes four register stages (products,
// pair sums, row sum, output register) before it leaves. Four row lanes
// run side by side, each with four 32x32 multipliers, then a registered
// two-level add tree at full precision (66 bits). The sum is shifted right
// by 16 (floor) and clamped to 32 bits, and the merge stage registers the
// four results with a flag set when any row was clamped. Every stage has its
// own valid bit, so a stalled output only holds back stages that are full.
// The matrix comes from eight 64-bit registers, two coefficients each (even
// column in bits 31:0, odd column in bits 63:32); reset loads the identity
// and writes to index 8 or above are dropped. Write them only while idle.
// ----------------------------------------------------------------------------
module mat4_vector_transform import mvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input vector word
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WordW-1:0]    s_axis_tdata,   // vec_x, vec_y, vec_z, vec_w
  // result word
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [WordW-1:0]    m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic                m_axis_tuser    // saturated
);

  // coefficient registers
  cfg_word_t cfg_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= CfgReset[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_idx_i[$clog2(NumRegs)-1:0]] <= cfg_wdata_i;
    end
  end

  // pipeline control: a stage loads when empty or when its successor loads
  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  stage_en_t stage_en;

  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign stage_en.ld1 = rdy1;
  assign stage_en.ld2 = rdy2;
  assign stage_en.ld3 = rdy3;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // unpack the vector, lowest component first
  coef_t vec [MatrixDim];
  for (genvar c = 0; c < MatrixDim; c++) begin : g_vec
    assign vec[c] = s_axis_tdata[c*CoefW +: CoefW];
  end

  // one lane per matrix row
  coef_t              lane_res [MatrixDim];
  logic [MatrixDim-1:0] lane_sat;

  for (genvar r = 0; r < MatrixDim; r++) begin : g_lane
    coef_t row_coef [MatrixDim];
    for (genvar c = 0; c < MatrixDim; c++) begin : g_coef
      assign row_coef[c] = cfg_q[r*(MatrixDim/2) + c/2][(c%2)*CoefW +: CoefW];
    end

    mvt_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (stage_en),
      .coef_i (row_coef),
      .vec_i  (vec),
      .res_o  (lane_res[r]),
      .sat_o  (lane_sat[r])
    );
  end

  // combine the rows into the output word
  mvt_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v3_q),
    .res_i         (lane_res),
    .sat_i         (lane_sat),
    .ready_o       (rdy4),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/mvt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_checker
// port-level checks on flow and occupancy of the transform block
// ----------------------------------------------------------------------------
module mvt_checker import mvt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [WordW-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cnt_d   = cnt_q + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != 3'd0)
    else $error("result word without an input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("more words in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled output");

endmodule

bind mat4_vector_transform mvt_checker u_mvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/mat4_vector_transform_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_vector_transform_tb
// self-checking regression for the 4x4 signed Q16.16 matrix-vector block
// ----------------------------------------------------------------------------
// A local transform model keeps its own copy of the eight matrix registers.
// It computes each row sum at full precision, floors it by 16 bits and
// clamps it to 32 bits. Every accepted vector word queues its predicted
// result word, and a monitor compares each result word field by field with
// the oldest prediction. The tests walk through the reset identity, dropped
// writes to unused indexes, saturation and rounding corners, and several
// random matrices with random stalls on both sides. A final back-to-back
// burst runs with no stalls at all.
// ----------------------------------------------------------------------------
module mat4_vector_transform_tb;
  import mvt_pkg::*;

  localparam longint OutMax = 64'sd2147483647;
  localparam longint OutMin = -64'sd2147483648;
  localparam int     DrainLimit = 20000;

  typedef logic [WordW-1:0] word_t;

  // predicted result word
  typedef struct {
    word_t data;
    logic  sat;
  } xform_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [WordW-1:0]    s_axis_tdata;   // vec_x, vec_y, vec_z, vec_w
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [WordW-1:0]    m_axis_tdata;   // out_x, out_y, out_z, out_w
  logic                m_axis_tuser;   // saturated

  // local copy of the matrix registers
  cfg_word_t matrix_regs [NumRegs];
  // predicted result words, oldest first
  xform_t    result_q [$];

  bit idle_on;
  int fail_cnt;
  int vec_cnt;
  int result_cnt;
  int sat_cnt;
  int write_cnt;

  string lane_name [MatrixDim] = '{"out_x", "out_y", "out_z", "out_w"};

  mat4_vector_transform dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("mat4_vector_transform regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // transform model
  // ---------------------------------------------------------------------------

  // coefficient of row r, column c: even column low half, odd column high half
  function automatic coef_t coef_at(input int r, input int c);
    cfg_word_t w;
    w = matrix_regs[r * 2 + c / 2];
    return (c % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  function automatic xform_t transform_vec(input word_t vin);
    xform_t                 res;
    logic signed [SumW-1:0] acc;
    logic signed [SumW-1:0] op_a;
    logic signed [SumW-1:0] op_b;
    logic signed [SumW-1:0] floored;
    coef_t                  lane;
    res.data = '0;
    res.sat  = 1'b0;
    for (int r = 0; r < MatrixDim; r++) begin
      acc = '0;
      for (int c = 0; c < MatrixDim; c++) begin
        // sign-extend both factors so the product is exact at 66 bits
        op_a = coef_at(r, c);
        lane = vin[c*CoefW +: CoefW];
        op_b = lane;
        acc  = acc + op_a * op_b;
      end
      // arithmetic shift floors toward minus infinity
      floored = acc >>> FracBits;
      if (floored > OutMax) begin
        lane    = 32'sh7fff_ffff;
        res.sat = 1'b1;
      end else if (floored < OutMin) begin
        lane    = 32'sh8000_0000;
        res.sat = 1'b1;
      end else begin
        lane = floored[CoefW-1:0];
      end
      res.data[r*CoefW +: CoefW] = lane;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers; each starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input cfg_word_t data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    // indexes past the register file are dropped by the block
    if (idx < NumRegs) matrix_regs[idx] = data;
    write_cnt++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_matrix(input cfg_word_t regs [NumRegs]);
    for (int i = 0; i < NumRegs; i++) cfg_write(CfgIdxW'(i), regs[i]);
  endtask

  // one vector word, with an optional idle burst ahead of it
  task automatic send_vec(input word_t v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    result_q.push_back(transform_vec(v));
    vec_cnt++;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every predicted word, then let the pipe settle
  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid = 1'b0;
    while (result_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (result_q.size() != 0) begin
      $error("%0d result words never arrived", result_q.size());
      fail_cnt++;
      result_q.delete();
    end
    repeat (8) @(negedge clk_i);
  endtask

  function automatic word_t pack_vec(input coef_t x, input coef_t y,
                                     input coef_t z, input coef_t w);
    return {w, z, y, x};
  endfunction

  // vector component: extremes, small magnitudes or full range
  function automatic coef_t rand_comp();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  // matrix coefficient; mode 0 stays near unity, mode 1 is full range, mode 2 mixes both
  function automatic coef_t rand_coef(input int mode);
    logic [31:0] r;
    r = $urandom;
    if (mode == 0 || (mode == 2 && $urandom_range(0, 1) == 0))
      return {{14{r[17]}}, r[17:0]};
    if ($urandom_range(0, 7) == 0)
      return ($urandom_range(0, 1) == 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // identity after reset passes every vector through untouched
  task automatic test_reset_identity();
    send_vec(pack_vec(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'shffff_ffff));
    send_vec(pack_vec(32'sh8000_0000, 32'sh7fff_ffff, 32'sh1, 32'sh0001_0000));
    send_vec(pack_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    drain_results();
  endtask

  // writes to indexes 8..15 must leave the matrix alone
  task automatic test_dropped_index();
    for (int i = NumRegs; i < (1 << CfgIdxW); i++)
      cfg_write(CfgIdxW'(i), {$urandom, $urandom});
    send_vec(pack_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    send_vec(pack_vec(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff));
    drain_results();
  endtask

  // saturation both ways, exact bounds, floor of negative fractions
  task automatic test_corner_values();
    cfg_word_t regs [NumRegs];
    // largest positive coefficients everywhere
    foreach (regs[i]) regs[i] = 64'h7fff_ffff_7fff_ffff;
    load_matrix(regs);
    send_vec(pack_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_vec(pack_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_vec(pack_vec(32'sh0, 32'sh0, 32'sh0, 32'sh0));
    drain_results();
    // most negative coefficients; min times min gives the largest sum
    foreach (regs[i]) regs[i] = 64'h8000_0000_8000_0000;
    load_matrix(regs);
    send_vec(pack_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_vec(pack_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_vec(pack_vec(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff));
    drain_results();
    // one lsb below zero everywhere: tiny negative sums must floor to -1
    foreach (regs[i]) regs[i] = 64'hffff_ffff_ffff_ffff;
    load_matrix(regs);
    send_vec(pack_vec(32'sh1, 32'sh1, 32'sh1, 32'sh1));
    send_vec(pack_vec(32'shffff_ffff, 32'sh0, 32'sh0, 32'sh0));
    send_vec(pack_vec(32'sh0001_0000, 32'shffff_0000, 32'sh3, 32'sh0));
    drain_results();
    // all zero matrix
    foreach (regs[i]) regs[i] = '0;
    load_matrix(regs);
    send_vec(pack_vec(32'sh7fff_ffff, 32'sh8000_0000, rand_comp(), rand_comp()));
    drain_results();
    // row 0 unity, row 1 max, row 2 min, row 3 mixed: rows clamp on their own
    regs[0] = 64'h0000_0000_0001_0000;
    regs[1] = 64'h0;
    regs[2] = 64'h0000_0000_7fff_ffff;
    regs[3] = 64'h0;
    regs[4] = 64'h0000_0000_8000_0000;
    regs[5] = 64'h0;
    regs[6] = 64'h8000_0000_7fff_ffff;
    regs[7] = 64'h0001_0000_ffff_0000;
    load_matrix(regs);
    // exactly one: rows land on the bounds with no clamp
    send_vec(pack_vec(32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0));
    // just above one: rows 1, 2 and 3 clamp
    send_vec(pack_vec(32'sh0001_0001, 32'sh0, 32'sh0, 32'sh0));
    send_vec(pack_vec(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
    send_vec(pack_vec(32'shffff_ffff, 32'sh1, 32'shffff_ffff, 32'sh1));
    drain_results();
  endtask

  // random matrices with random vectors and random stalls on both sides
  task automatic test_random_matrices();
    cfg_word_t regs [NumRegs];
    idle_on = 1'b1;
    for (int p = 0; p < 7; p++) begin
      foreach (regs[i]) regs[i] = {rand_coef(p % 3), rand_coef(p % 3)};
      load_matrix(regs);
      for (int n = 0; n < 250; n++) begin
        send_vec(pack_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
        // hold the sender off once until the pipe is empty
        if (p == 2 && n == 120) drain_results();
      end
      drain_results();
    end
  endtask

  // full-rate burst with no idling on either side
  task automatic test_back_to_back();
    cfg_word_t regs [NumRegs];
    idle_on = 1'b0;
    foreach (regs[i]) regs[i] = {rand_coef(2), rand_coef(2)};
    load_matrix(regs);
    for (int n = 0; n < 250; n++)
      send_vec(pack_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, then the scoreboard
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        // random-length burst of stalled cycles
        stall_left    = $urandom_range(0, 3);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    xform_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("result word with no prediction pending: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        result_cnt++;
        if (m_axis_tuser) sat_cnt++;
        for (int r = 0; r < MatrixDim; r++) begin
          if (m_axis_tdata[r*CoefW +: CoefW] !== want.data[r*CoefW +: CoefW]) begin
            $error("%s mismatch: expected %h, got %h", lane_name[r],
                   want.data[r*CoefW +: CoefW], m_axis_tdata[r*CoefW +: CoefW]);
            fail_cnt++;
          end
        end
        if (m_axis_tuser !== want.sat) begin
          $error("saturated mismatch: expected %b, got %b", want.sat, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b1;
    fail_cnt      = 0;
    vec_cnt       = 0;
    result_cnt    = 0;
    sat_cnt       = 0;
    write_cnt     = 0;
    foreach (matrix_regs[i]) matrix_regs[i] = CfgReset[i];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_identity();
    test_dropped_index();
    test_corner_values();
    test_random_matrices();
    test_back_to_back();

    $display("covered %0d vector words, %0d result words (%0d saturated)",
             vec_cnt, result_cnt, sat_cnt);
    $display("matrix writes: %0d, including dropped indexes and extreme matrices",
             write_cnt);
    if (fail_cnt == 0) begin
      $display("mat4_vector_transform regression: pass");
    end else begin
      $display("mat4_vector_transform regression: fail");
    end
    $finish;
  end

endmodule
